/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PCX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PCX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcxrd_pkg.sv */
// Package of types and constants for the PCX run-length pixel decoder.
package pcxrd_pkg;

    localparam int unsigned MAX_WIDTH  = 640;
    localparam int unsigned MAX_HEIGHT = 480;

    localparam int unsigned W_BITS    = 10;
    localparam int unsigned H_BITS    = 9;
    localparam int unsigned ADDR_BITS = 19;
    localparam int unsigned BUDGET_BITS = 20;
    localparam int unsigned BYTES_BITS  = 21;
    localparam int unsigned CNT_BITS    = 6;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_QUARTER = 2'd2;
    localparam logic [1:0] REG_BUDGET  = 2'd3;

    // Top two bits of a run header byte.
    localparam logic [1:0] RUN_MARK = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MULT,
        ST_RUN
    } t_state;

    // Effective geometry after clamping.
    typedef struct packed {
        logic [W_BITS-1:0]      width;
        logic [H_BITS-1:0]      height;
        logic [W_BITS-1:0]      stride;
        logic                   quarter;
        logic [BUDGET_BITS-1:0] budget;
    } t_cfg;

    // One pixel write.
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           value;
        logic                 run_end;
        logic                 image_end;
        logic                 malformed;
    } t_pix;

endpackage

/* sv/pcxrd_cfg_regs.sv */
// Configuration registers of the decoder with clamping of the image size.
module pcxrd_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [19:0]           i_cfg_data,
    output pcxrd_pkg::t_cfg       o_cfg
);
    import pcxrd_pkg::*;

    logic [W_BITS-1:0]      r_width;
    logic [H_BITS-1:0]      r_height;
    logic                   r_quarter;
    logic [BUDGET_BITS-1:0] r_budget;
    logic [W_BITS-1:0]      w_width;
    logic [H_BITS-1:0]      w_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= W_BITS'(MAX_WIDTH);
            r_height  <= H_BITS'(MAX_HEIGHT);
            r_quarter <= 1'b0;
            r_budget  <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:   r_width   <= i_cfg_data[W_BITS-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[H_BITS-1:0];
                REG_QUARTER: r_quarter <= i_cfg_data[0];
                REG_BUDGET:  r_budget  <= i_cfg_data[BUDGET_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // A size of zero counts as one; anything above the maximum saturates.
    always_comb begin
        if (r_width == '0) begin
            w_width = W_BITS'(1);
        end else if (r_width > W_BITS'(MAX_WIDTH)) begin
            w_width = W_BITS'(MAX_WIDTH);
        end else begin
            w_width = r_width;
        end
        if (r_height == '0) begin
            w_height = H_BITS'(1);
        end else if (r_height > H_BITS'(MAX_HEIGHT)) begin
            w_height = H_BITS'(MAX_HEIGHT);
        end else begin
            w_height = r_height;
        end
    end

    assign o_cfg.width   = w_width;
    assign o_cfg.height  = w_height;
    assign o_cfg.stride  = r_quarter ? {2'b00, w_width[W_BITS-1:2]} : w_width;
    assign o_cfg.quarter = r_quarter;
    assign o_cfg.budget  = r_budget;

endmodule

/* sv/pcxrd_out_reg.sv */
// Output register holding one pixel word until the receiver takes it.
module pcxrd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pcxrd_pkg::t_pix   i_pix,
    output logic              o_free,
    input  logic              i_stall,
    output logic              o_valid,
    output pcxrd_pkg::t_pix   o_pix
);
    import pcxrd_pkg::*;

    logic r_valid;
    t_pix r_pix;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

/* sv/pcxrd_seq.sv */
// Byte decoder and column sequencer that steps one column per cycle unless a kept pixel waits for the output register.
module pcxrd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    output logic              o_in_stall,
    input  pcxrd_pkg::t_cfg   i_cfg,
    input  logic              i_out_free,
    output logic              o_load,
    output pcxrd_pkg::t_pix   o_pix
);
    import pcxrd_pkg::*;

    t_state r_state, n_state;
    logic [W_BITS-1:0]     r_column, n_column;
    logic [H_BITS-1:0]     r_row, n_row;
    logic                  r_await, n_await;
    logic [CNT_BITS-1:0]   r_pend, n_pend;
    logic [BYTES_BITS-1:0] r_bytes, n_bytes;
    logic                  r_done, n_done;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [7:0]            r_value, n_value;
    logic [ADDR_BITS-1:0]  r_row_base, n_row_base;
    logic                  r_fin, n_fin;

    logic                  w_accept;
    logic                  w_await, w_done, w_header;
    logic [CNT_BITS-1:0]   w_pend, w_count;
    logic [BYTES_BITS-1:0] w_bytes;
    logic                  w_start;
    logic                  w_wrap;
    logic [H_BITS-1:0]     w_row_n;
    logic                  w_wrap_end;
    logic [ADDR_BITS-1:0]  w_prod;
    logic [CNT_BITS-1:0]   w_rem;
    logic                  w_keep, w_step, w_row_end, w_last_row, w_last_kept;
    logic [W_BITS-1:0]     w_x;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // A new image clears everything before the byte is decoded.
    assign w_await  = i_first_byte ? 1'b0 : r_await;
    assign w_pend   = i_first_byte ? '0 : r_pend;
    assign w_bytes  = i_first_byte ? '0 : r_bytes;
    assign w_done   = i_first_byte ? 1'b0 : r_done;
    assign w_header = !w_await && (i_data_byte[7:6] == RUN_MARK);
    assign w_count  = w_await ? w_pend : CNT_BITS'(1);
    assign w_start  = w_accept && !w_done && !w_header && (w_count != '0);

    // Column past the row end at the start of a run moves to the next row.
    assign w_wrap     = (r_column >= i_cfg.width);
    assign w_row_n    = w_wrap ? r_row + H_BITS'(1) : r_row;
    assign w_wrap_end = (w_row_n >= i_cfg.height);

    assign w_prod = {10'b0, r_row} * {9'b0, i_cfg.stride};

    assign w_rem      = r_count - CNT_BITS'(1);
    assign w_keep     = !i_cfg.quarter || (r_column[1:0] == 2'b00);
    assign w_step     = !w_keep || i_out_free;
    assign w_row_end  = ({1'b0, r_column} + 11'd1) >= {1'b0, i_cfg.width};
    assign w_last_row = ({1'b0, r_row} + 10'd1) >= {1'b0, i_cfg.height};
    // In quarter mode the next kept column is four further on.
    assign w_last_kept = i_cfg.quarter
        ? ((w_rem < CNT_BITS'(4)) || (({1'b0, r_column} + 11'd4) >= {1'b0, i_cfg.width}))
        : ((w_rem == '0) || w_row_end);
    assign w_x = i_cfg.quarter ? {2'b00, r_column[W_BITS-1:2]} : r_column;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                n_state = w_wrap_end ? ST_IDLE : ST_MULT;
            end
            ST_MULT: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_step && (w_row_end || (w_rem == '0))) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_column   = r_column;
        n_row      = r_row;
        n_await    = r_await;
        n_pend     = r_pend;
        n_bytes    = r_bytes;
        n_done     = r_done;
        n_count    = r_count;
        n_value    = r_value;
        n_row_base = r_row_base;
        n_fin      = r_fin;
        o_load     = 1'b0;
        o_pix.addr      = r_row_base + ADDR_BITS'(w_x);
        o_pix.value     = r_value;
        o_pix.run_end   = w_last_kept;
        o_pix.image_end = w_last_kept && r_fin;
        o_pix.malformed = w_last_kept && r_fin && (r_bytes > {1'b0, i_cfg.budget});
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_first_byte) begin
                        n_column = '0;
                        n_row    = '0;
                        n_await  = 1'b0;
                        n_pend   = '0;
                        n_bytes  = '0;
                        n_done   = 1'b0;
                    end
                    if (!w_done) begin
                        n_bytes = (w_bytes == '1) ? w_bytes : w_bytes + BYTES_BITS'(1);
                        if (w_header) begin
                            n_pend  = i_data_byte[CNT_BITS-1:0];
                            n_await = 1'b1;
                        end else begin
                            n_await = 1'b0;
                            n_pend  = '0;
                            n_count = w_count;
                            n_value = i_data_byte;
                        end
                    end
                end
            end
            ST_WRAP: begin
                if (w_wrap) begin
                    n_column = '0;
                    n_row    = w_row_n;
                end
                if (w_wrap_end) begin
                    n_done = 1'b1;
                end
            end
            ST_MULT: begin
                n_row_base = w_prod;
                // The run finishes the image when it reaches the end of the last row.
                n_fin = (({1'b0, r_column} + 11'(r_count)) >= {1'b0, i_cfg.width})
                        && w_last_row;
            end
            ST_RUN: begin
                o_load = w_keep && i_out_free;
                if (w_step) begin
                    n_count = w_rem;
                    if (w_row_end) begin
                        n_column = '0;
                        n_row    = r_row + H_BITS'(1);
                        if (w_last_row) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_column = r_column + W_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_column <= '0;
            r_row    <= '0;
            r_await  <= 1'b0;
            r_pend   <= '0;
            r_bytes  <= '0;
            r_done   <= 1'b1;
            r_count  <= '0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_column <= n_column;
            r_row    <= n_row;
            r_await  <= n_await;
            r_pend   <= n_pend;
            r_bytes  <= n_bytes;
            r_done   <= n_done;
            r_count  <= n_count;
            r_fin    <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_row_base <= n_row_base;
    end

endmodule

/* sv/pcx_rle_pixel_decoder_top.sv */
// Top level of the PCX 8-bit run-length pixel decoder.
// The input channel takes one compressed byte per word, with first_byte set on the
// first data byte of an image; a word is taken when i_in_valid is high and o_in_stall
// is low. Each pixel write leaves on the output channel as one word carrying its
// row-major address, its palette index and the run, image and malformed flags; it is
// taken when o_out_valid is high and i_out_stall is low. Configuration registers
// (width, height, quarter-width mode, byte budget) are written through i_cfg_valid
// and o_cfg_ready, which is always high, and should only be written between bytes.
// A run header byte is absorbed without leaving idle. A literal or a run value passes
// through the set-up states (row wrap check, row base multiply) and then the column
// loop, one column per cycle unless a kept pixel waits; the input stays stalled from
// the set-up states until the run ends, so the next byte is taken only after the last
// column. In quarter-width mode dropped columns are still stepped through by the
// column loop, which sets the rate.
// Synchronous reset restores the default configuration and leaves the block idle
// until a byte with first_byte set arrives. If the receiver stalls, the output
// register holds its word and the column loop waits on the next kept pixel.
module pcx_rle_pixel_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [18:0] o_out_pixel_addr,
    output logic [7:0]  o_out_pixel_value,
    output logic        o_out_run_end,
    output logic        o_out_image_end,
    output logic        o_out_malformed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import pcxrd_pkg::*;

    t_cfg w_cfg;
    t_pix w_pix_load;
    t_pix w_pix_out;
    logic w_load;
    logic w_out_free;

    // The register file never refuses a write.
    assign o_cfg_ready = 1'b1;

    pcxrd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pcxrd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_in_data_byte),
        .i_first_byte (i_in_first_byte),
        .o_in_stall   (o_in_stall),
        .i_cfg        (w_cfg),
        .i_out_free   (w_out_free),
        .o_load       (w_load),
        .o_pix        (w_pix_load)
    );

    pcxrd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_pix   (w_pix_load),
        .o_free  (w_out_free),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_pix   (w_pix_out)
    );

    assign o_out_pixel_addr  = w_pix_out.addr;
    assign o_out_pixel_value = w_pix_out.value;
    assign o_out_run_end     = w_pix_out.run_end;
    assign o_out_image_end   = w_pix_out.image_end;
    assign o_out_malformed   = w_pix_out.malformed;

endmodule

/* sv/pcxrd_checker.sv */
// Port-level checker for the decoder, bound to the top level.
`include "assert_macros.svh"

module pcxrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_data_byte,
    input logic        i_in_first_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [18:0] o_out_pixel_addr,
    input logic [7:0]  o_out_pixel_value,
    input logic        o_out_run_end,
    input logic        o_out_image_end,
    input logic        o_out_malformed
);
    import pcxrd_pkg::*;

    // The image can only end on the last pixel of a byte.
    `PCX_ASSERT_IMP(a_end_on_run_end, i_clk, i_rst_n,
        o_out_valid && o_out_image_end, o_out_run_end, "image_end without run_end")

    // The malformed flag only travels with the end of the image.
    `PCX_ASSERT_IMP(a_malformed_at_end, i_clk, i_rst_n,
        o_out_valid && o_out_malformed, o_out_image_end, "malformed outside image end")

    // A stalled output word holds.
    `PCX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_pixel_addr) && $stable(o_out_pixel_value),
        "stalled output word changed")

    // A literal that opens an image always starts the column loop.
    `PCX_ASSERT_NXT(a_literal_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_first_byte && (i_in_data_byte[7:6] != RUN_MARK),
        o_in_stall, "literal did not start a run")

endmodule

bind pcx_rle_pixel_decoder_top pcxrd_checker u_pcxrd_checker (.*);
